>>> hw/rtl/iff_pkg.sv
// shared constants, segment codes and digit lookup for the integer field formatter
`default_nettype none

package iff_pkg;

	localparam int unsigned CNT_W     = 7;   // character counts, up to 64
	localparam int unsigned NDIG      = 22;  // digit slots, enough for 64-bit octal
	localparam int unsigned DIG_W     = 4 * NDIG;
	localparam int unsigned ND_W      = 5;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [2:0]       seg_t;

	localparam seg_t SEG_PADF = 3'd0;
	localparam seg_t SEG_LEAD = 3'd1;
	localparam seg_t SEG_ZPAD = 3'd2;
	localparam seg_t SEG_ZERO = 3'd3;
	localparam seg_t SEG_DIGS = 3'd4;
	localparam seg_t SEG_PADB = 3'd5;

	localparam logic [1:0] BASE_DEC  = 2'd0;
	localparam logic [1:0] BASE_OCT  = 2'd1;
	localparam logic [1:0] BASE_HEXL = 2'd2;
	localparam logic [1:0] BASE_HEXU = 2'd3;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_LX    = 8'h78;
	localparam logic [7:0] CH_UX    = 8'h58;

	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] c;
		if (d < 4'd10)
			c = CH_ZERO + {4'd0, d};
		else if (upper)
			c = 8'h37 + {4'd0, d};
		else
			c = 8'h57 + {4'd0, d};
		return c;
	endfunction

endpackage

`default_nettype wire

>>> hw/rtl/integer_field_formatter.sv
// integer field formatter: printf-style integer conversion, one character per output request
`default_nettype none

// Formats one integer with its conversion spec and sends the field's ASCII characters one
// per output request, with last on the final one. Input is taken only while the block is
// idle (in_stall low); the output register may still hold the previous field's last
// character. An item goes through: an accept step; for decimal or signed items, a
// shift-and-add-3 binary to BCD unit (octal and hex load their digits on accept); a
// leading-zero digit scan, one nibble per cycle; a planning step; then the field's
// characters, with a switch step between field segments (at most five).
module integer_field_formatter
	import iff_pkg::*;
#(
	parameter int unsigned MAX_FIELD_CHARS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] value,
	input  wire logic        wide,
	input  wire logic        is_signed,
	input  wire logic [1:0]  base_sel,
	input  wire logic        flag_left,
	input  wire logic        flag_zero,
	input  wire logic        flag_plus,
	input  wire logic        flag_space,
	input  wire logic        flag_alt,
	input  wire logic [6:0]  field_width,
	input  wire logic [5:0]  min_digits,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_char,
	output logic             last
);

	localparam cnt_t MAX_C = cnt_t'(MAX_FIELD_CHARS);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CONV = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_PLAN = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;

	logic [2:0]       state_q;
	logic [63:0]      mag_q;
	logic [DIG_W-1:0] dig_q;
	logic [5:0]       iter_q;
	logic [ND_W-1:0]  nd_q;
	logic             upper_q;
	logic             left_q;
	logic             zero_q;
	logic             alt_oct_q;
	cnt_t             width_q;
	cnt_t             prec_q;
	logic [15:0]      lead_q;
	logic [1:0]       nlead_q;
	cnt_t             zp_q, zeros_q, pb_q;
	cnt_t             rem_q;
	cnt_t             total_q;
	seg_t             seg_q;
	logic             ovalid_q;
	logic [7:0]       ochar_q;
	logic             olast_q;

	// accept-cycle decode
	logic [63:0] v_ext;
	logic        neg;
	logic [63:0] mag;
	logic        dec;
	logic [65:0] mag_x;
	logic [DIG_W-1:0] oct_dig, hex_dig;
	logic [15:0] lead_in;
	logic [1:0]  nlead_in;

	always_comb begin
		v_ext = wide ? value : {{32{is_signed & value[31]}}, value[31:0]};
		neg   = is_signed & v_ext[63];
		mag   = neg ? (64'd0 - v_ext) : v_ext;
		dec   = is_signed | (base_sel == BASE_DEC);
		mag_x = {2'b00, mag};
		for (int i = 0; i < NDIG; i++)
			oct_dig[4*i +: 4] = {1'b0, mag_x[3*i +: 3]};
		hex_dig = {{(DIG_W-64){1'b0}}, mag};
		lead_in  = 16'd0;
		nlead_in = 2'd0;
		if (is_signed) begin
			if (neg) begin
				lead_in  = {CH_MINUS, 8'd0};
				nlead_in = 2'd1;
			end else if (flag_plus) begin
				lead_in  = {CH_PLUS, 8'd0};
				nlead_in = 2'd1;
			end else if (flag_space) begin
				lead_in  = {CH_SPACE, 8'd0};
				nlead_in = 2'd1;
			end
		end else if (flag_alt && base_sel[1] && mag != 64'd0) begin
			lead_in  = {CH_ZERO, (base_sel == BASE_HEXU) ? CH_UX : CH_LX};
			nlead_in = 2'd2;
		end
	end

	// shift-and-add-3 step of the bcd unit
	logic [DIG_W-1:0] dd_adj;
	always_comb begin
		for (int i = 0; i < NDIG; i++)
			dd_adj[4*i +: 4] = (dig_q[4*i +: 4] >= 4'd5) ? dig_q[4*i +: 4] + 4'd3
				: dig_q[4*i +: 4];
	end

	// field planning
	cnt_t prec_lim, prec_c, nd_c, zeros_c, body_c, wid_c, pad_c;
	logic oct_lead;
	logic [1:0] nlead_c;
	always_comb begin
		prec_lim = MAX_C - cnt_t'(nlead_q);
		prec_c   = (prec_q > prec_lim) ? prec_lim : prec_q;
		nd_c     = cnt_t'(nd_q);
		zeros_c  = (prec_c > nd_c) ? prec_c - nd_c : '0;
		oct_lead = alt_oct_q && (zeros_c == '0) && (dig_q[DIG_W-1 -: 4] != 4'd0);
		nlead_c  = oct_lead ? 2'd1 : nlead_q;
		body_c   = cnt_t'(nlead_c) + zeros_c + nd_c;
		wid_c    = (width_q > MAX_C) ? MAX_C : width_q;
		pad_c    = (wid_c > body_c) ? wid_c - body_c : '0;
	end

	// segment sequencing
	logic       slot_free;
	logic [7:0] seg_char;
	cnt_t       next_rem;
	seg_t       next_seg;
	assign slot_free = !ovalid_q || !out_stall;
	assign next_seg  = seg_q + seg_t'(1);

	always_comb begin
		unique case (next_seg)
			SEG_LEAD: next_rem = cnt_t'(nlead_q);
			SEG_ZPAD: next_rem = zp_q;
			SEG_ZERO: next_rem = zeros_q;
			SEG_DIGS: next_rem = cnt_t'(nd_q);
			SEG_PADB: next_rem = pb_q;
			default:  next_rem = '0;
		endcase
		unique case (seg_q)
			SEG_LEAD: seg_char = lead_q[15:8];
			SEG_ZPAD: seg_char = CH_ZERO;
			SEG_ZERO: seg_char = CH_ZERO;
			SEG_DIGS: seg_char = digit_char(dig_q[DIG_W-1 -: 4], upper_q);
			default:  seg_char = CH_SPACE;
		endcase
	end

	logic emit;
	assign emit = (state_q == S_EMIT) && (rem_q != '0) && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (emit)
				ovalid_q <= 1'b1;
			else if (!out_stall)
				ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= dec ? S_CONV : S_SCAN;
				end
				S_CONV: begin
					if (iter_q == 6'd0)
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (dig_q[DIG_W-1 -: 4] != 4'd0 || nd_q == ND_W'(1))
						state_q <= S_PLAN;
				end
				S_PLAN: state_q <= S_EMIT;
				S_EMIT: begin
					if (emit && total_q == cnt_t'(1))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			ochar_q <= seg_char;
			olast_q <= (total_q == cnt_t'(1));
		end
		unique case (state_q)
			S_IDLE: begin
				mag_q     <= mag;
				dig_q     <= dec ? '0 : (base_sel == BASE_OCT ? oct_dig : hex_dig);
				iter_q    <= 6'd63;
				nd_q      <= ND_W'(NDIG);
				upper_q   <= !is_signed && (base_sel == BASE_HEXU);
				left_q    <= flag_left;
				zero_q    <= flag_zero;
				alt_oct_q <= !is_signed && flag_alt && (base_sel == BASE_OCT);
				width_q   <= field_width;
				prec_q    <= cnt_t'(min_digits);
				lead_q    <= lead_in;
				nlead_q   <= nlead_in;
			end
			S_CONV: begin
				dig_q  <= {dd_adj[DIG_W-2:0], mag_q[63]};
				mag_q  <= {mag_q[62:0], 1'b0};
				iter_q <= iter_q - 6'd1;
			end
			S_SCAN: begin
				// strip leading zero digits, keep at least one
				if (dig_q[DIG_W-1 -: 4] == 4'd0 && nd_q != ND_W'(1)) begin
					dig_q <= {dig_q[DIG_W-5:0], 4'd0};
					nd_q  <= nd_q - ND_W'(1);
				end
			end
			S_PLAN: begin
				if (oct_lead) begin
					lead_q <= {CH_ZERO, 8'd0};
				end
				nlead_q <= nlead_c;
				zeros_q <= zeros_c;
				zp_q    <= (!left_q && zero_q) ? pad_c : '0;
				pb_q    <= left_q ? pad_c : '0;
				total_q <= pad_c + body_c;
				seg_q   <= SEG_PADF;
				rem_q   <= (!left_q && !zero_q) ? pad_c : '0;
			end
			S_EMIT: begin
				if (rem_q == '0) begin
					seg_q <= next_seg;
					rem_q <= next_rem;
				end else if (emit) begin
					rem_q   <= rem_q - cnt_t'(1);
					total_q <= total_q - cnt_t'(1);
					if (seg_q == SEG_LEAD)
						lead_q <= {lead_q[7:0], 8'd0};
					if (seg_q == SEG_DIGS)
						dig_q <= {dig_q[DIG_W-5:0], 4'd0};
				end
			end
			default: ;
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = ovalid_q;
	assign out_char  = ochar_q;
	assign last      = olast_q;

endmodule

`default_nettype wire

>>> tb/iff_field_checker.sv
// request and character channel monitor with field prediction for the integer field formatter
`timescale 1ns / 100ps

module iff_field_checker
	import iff_pkg::*;
#(
	parameter int unsigned MAX_FIELD_CHARS = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [63:0] value,
	input  wire logic        wide,
	input  wire logic        is_signed,
	input  wire logic [1:0]  base_sel,
	input  wire logic        flag_left,
	input  wire logic        flag_zero,
	input  wire logic        flag_plus,
	input  wire logic        flag_space,
	input  wire logic        flag_alt,
	input  wire logic [6:0]  field_width,
	input  wire logic [5:0]  min_digits,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  out_char,
	input  wire logic        last,
	output int               fail_count,
	output int               pending
);

	localparam logic [7:0] CH_UA = 8'h41;
	localparam logic [7:0] CH_LA = 8'h61;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} field_char_t;

	field_char_t expected_chars[$];

	initial begin
		fail_count = 0;
		pending <= 0;
	end

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		fail_count++;
	endtask

	// builds the whole field text for one request, before the character limit
	function automatic void render_field(
		input logic [63:0] raw,
		input logic        wide_op,
		input logic        sgn,
		input logic [1:0]  bsel,
		input logic        left,
		input logic        zero,
		input logic        plus,
		input logic        space,
		input logic        alt,
		input logic [6:0]  fw,
		input logic [5:0]  md,
		output logic [7:0] text[$]
	);
		logic [63:0] mag;
		logic [7:0]  lead[$];
		logic [7:0]  digs[$];
		int unsigned radix;
		int unsigned dv;
		int unsigned prec;
		int unsigned width;
		int unsigned zeros;
		int unsigned body;
		int unsigned pad;
		logic        upper;

		text = {};
		lead = {};
		digs = {};
		radix = 10;
		upper = 1'b0;
		mag = raw;
		if (!wide_op) begin
			mag = {32'd0, raw[31:0]};
			if (sgn && raw[31])
				mag[63:32] = '1;
		end

		if (sgn) begin
			if (mag[63]) begin
				lead.push_back(CH_MINUS);
				mag = -mag;
			end else if (plus)
				lead.push_back(CH_PLUS);
			else if (space)
				lead.push_back(CH_SPACE);
		end else begin
			case (bsel)
				BASE_OCT:  radix = 8;
				BASE_HEXL: radix = 16;
				BASE_HEXU: begin
					radix = 16;
					upper = 1'b1;
				end
				default:   radix = 10;
			endcase
			if (alt && radix == 16 && mag != 0) begin
				lead.push_back(CH_ZERO);
				lead.push_back(upper ? CH_UX : CH_LX);
			end
		end

		// least significant digit first
		do begin
			dv = 32'(mag % radix);
			if (dv < 10)
				digs.push_back(CH_ZERO + 8'(dv));
			else
				digs.push_back((upper ? CH_UA : CH_LA) + 8'(dv - 10));
			mag = mag / radix;
		end while (mag != 0);

		prec = md;
		if (prec + lead.size() > MAX_FIELD_CHARS)
			prec = MAX_FIELD_CHARS - lead.size();
		zeros = (prec > digs.size()) ? prec - digs.size() : 0;

		// octal alternate form only adds a zero when none leads already
		if (!sgn && alt && radix == 8 && zeros == 0 && digs[digs.size() - 1] != CH_ZERO)
			lead.push_back(CH_ZERO);

		body = lead.size() + zeros + digs.size();
		width = (fw > MAX_FIELD_CHARS) ? MAX_FIELD_CHARS : fw;
		pad = (width > body) ? width - body : 0;

		if (!left && !zero)
			repeat (pad) text.push_back(CH_SPACE);
		foreach (lead[i])
			text.push_back(lead[i]);
		if (!left && zero)
			repeat (pad) text.push_back(CH_ZERO);
		repeat (zeros) text.push_back(CH_ZERO);
		for (int i = digs.size() - 1; i >= 0; i--)
			text.push_back(digs[i]);
		if (left)
			repeat (pad) text.push_back(CH_SPACE);
	endfunction

	always @(posedge clk) begin
		field_char_t want;
		logic [7:0]  text[$];
		int          n;

		if (arst_n) begin
			// characters first: nothing from a request accepted on this edge can be out yet
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0)
					report_mismatch($sformatf("unexpected character 0x%02h last %0b",
						out_char, last));
				else begin
					want = expected_chars.pop_front();
					if (out_char !== want.ch)
						report_mismatch($sformatf("out_char 0x%02h, predicted 0x%02h",
							out_char, want.ch));
					if (last !== want.last)
						report_mismatch($sformatf("last %0b, predicted %0b on char 0x%02h",
							last, want.last, want.ch));
				end
			end

			if (in_valid && !in_stall) begin
				render_field(value, wide, is_signed, base_sel, flag_left, flag_zero,
					flag_plus, flag_space, flag_alt, field_width, min_digits, text);
				n = (text.size() > MAX_FIELD_CHARS) ? MAX_FIELD_CHARS : text.size();
				for (int i = 0; i < n; i++)
					expected_chars.push_back({text[i], i == n - 1});
			end

			pending <= expected_chars.size();
		end
	end

endmodule

>>> tb/tb_top.sv
// stimulus, idling control and verdict for the integer field formatter
`timescale 1ns / 100ps

module tb_top;
	import iff_pkg::*;

	localparam int unsigned FIELD_LIMIT    = 64;
	localparam int          HOLDOFF_CYCLES = 400;
	localparam int          DRAIN_CYCLES   = 200;
	localparam int          STUCK_LIMIT    = 5000;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [63:0] value       = '0;
	logic        wide        = 1'b0;
	logic        is_signed   = 1'b0;
	logic [1:0]  base_sel    = BASE_DEC;
	logic        flag_left   = 1'b0;
	logic        flag_zero   = 1'b0;
	logic        flag_plus   = 1'b0;
	logic        flag_space  = 1'b0;
	logic        flag_alt    = 1'b0;
	logic [6:0]  field_width = '0;
	logic [5:0]  min_digits  = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [7:0]  out_char;
	logic        last;
	int          fail_count;
	int          pending;

	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	logic        holdoff_start  = 1'b0;
	int          holdoff_cnt    = 0;
	int          stuck_cycles   = 0;

	integer_field_formatter #(.MAX_FIELD_CHARS(FIELD_LIMIT)) dut (.*);

	iff_field_checker #(.MAX_FIELD_CHARS(FIELD_LIMIT)) checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// receiver side: random stalls, or a long hold-off counted here
	always @(posedge clk) begin
		if (holdoff_cnt != 0) begin
			out_stall <= 1'b1;
			holdoff_cnt <= holdoff_cnt - 1;
		end else if (holdoff_start) begin
			out_stall <= 1'b1;
			holdoff_cnt <= HOLDOFF_CYCLES;
		end else
			out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck_cycles <= 0;
			else if (stuck_cycles >= STUCK_LIMIT) begin
				$display("FAIL integer_field_formatter");
				$finish;
			end else
				stuck_cycles <= stuck_cycles + 1;
		end
	end

	task automatic offer_request(
		input logic [63:0] v,
		input logic        w,
		input logic        sgn,
		input logic [1:0]  bsel,
		input logic        left,
		input logic        zero,
		input logic        plus,
		input logic        space,
		input logic        alt,
		input logic [6:0]  fw,
		input logic [5:0]  md
	);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		value       <= v;
		wide        <= w;
		is_signed   <= sgn;
		base_sel    <= bsel;
		flag_left   <= left;
		flag_zero   <= zero;
		flag_plus   <= plus;
		flag_space  <= space;
		flag_alt    <= alt;
		field_width <= fw;
		min_digits  <= md;
		in_valid    <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	initial begin
		logic [63:0] val;
		logic [4:0]  flags;
		logic [6:0]  fw;
		logic [5:0]  md;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero, extremes, narrow operands, every base and flag interplay, clamped sizes
		offer_request(64'd0, 1, 0, BASE_DEC, 0, 0, 0, 0, 0, 7'd0, 6'd0);
		offer_request(64'd0, 1, 1, BASE_DEC, 0, 0, 0, 0, 0, 7'd0, 6'd0);
		offer_request('1, 1, 0, BASE_DEC, 0, 0, 0, 0, 0, 7'd0, 6'd0);
		offer_request(64'h8000_0000_0000_0000, 1, 1, BASE_DEC, 0, 0, 0, 0, 0, 7'd0, 6'd0);
		offer_request(64'hDEAD_BEEF_8000_0000, 0, 1, BASE_DEC, 0, 0, 1, 0, 0, 7'd0, 6'd0);
		offer_request('1, 1, 0, BASE_OCT, 0, 0, 0, 0, 1, 7'd0, 6'd0);
		offer_request(64'd0, 1, 0, BASE_OCT, 0, 0, 0, 0, 1, 7'd0, 6'd0);
		offer_request(64'd8, 1, 0, BASE_OCT, 0, 0, 0, 0, 1, 7'd0, 6'd5);
		offer_request(64'o17, 1, 0, BASE_OCT, 0, 0, 0, 0, 1, 7'd0, 6'd2);
		offer_request(64'o777, 0, 0, BASE_OCT, 0, 0, 0, 0, 1, 7'd6, 6'd2);
		offer_request(64'd0, 1, 0, BASE_HEXL, 0, 0, 0, 0, 1, 7'd4, 6'd0);
		offer_request(64'd255, 1, 0, BASE_HEXL, 0, 1, 0, 0, 1, 7'd10, 6'd0);
		offer_request(64'hABC, 1, 0, BASE_HEXU, 1, 1, 0, 0, 1, 7'd12, 6'd0);
		offer_request('1, 1, 0, BASE_HEXU, 0, 0, 0, 0, 1, 7'd0, 6'd0);
		offer_request(64'd42, 1, 1, BASE_HEXU, 0, 0, 1, 1, 1, 7'd0, 6'd0);
		offer_request(64'd42, 0, 1, BASE_DEC, 0, 0, 0, 1, 0, 7'd5, 6'd0);
		offer_request(-64'd42, 1, 1, BASE_DEC, 0, 1, 0, 0, 0, 7'd8, 6'd0);
		offer_request(64'd42, 1, 0, BASE_DEC, 1, 0, 1, 1, 0, 7'd20, 6'd3);
		offer_request(64'd7, 1, 0, BASE_DEC, 0, 0, 0, 0, 0, 7'd127, 6'd0);
		offer_request(64'h8000_0000_0000_0000, 1, 1, BASE_DEC, 0, 0, 0, 0, 0, 7'd0, 6'd63);
		offer_request(64'h1234, 1, 0, BASE_HEXL, 0, 0, 0, 0, 1, 7'd0, 6'd63);
		offer_request('1, 0, 0, BASE_DEC, 0, 1, 0, 0, 0, 7'd64, 6'd62);
		offer_request(64'd5, 1, 1, BASE_DEC, 1, 0, 1, 0, 0, 7'd64, 6'd63);
		offer_request(64'hFFFF_FFFF_7FFF_FFFF, 0, 1, BASE_DEC, 0, 1, 0, 1, 0, 7'd15, 6'd12);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct <= 78;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct <= 0;
					recv_stall_pct <= 78;
				end
				default: begin
					send_idle_pct <= 35;
					recv_stall_pct <= 35;
				end
			endcase
			for (int k = 0; k < 77; k++) begin
				if (ph == 0 && k == 30) begin
					// long receiver hold-off while requests keep coming
					in_valid <= 1'b0;
					holdoff_start <= 1'b1;
					@(posedge clk);
					holdoff_start <= 1'b0;
				end
				if (ph == 2 && k == 40) begin
					in_valid <= 1'b0;
					do @(posedge clk); while (pending != 0);
				end

				case ($urandom_range(5))
					0: val = {$urandom, $urandom};
					1: val = 64'($urandom_range(20));
					2: val = 64'd1 << $urandom_range(63);
					3: val = ~(64'd1 << $urandom_range(63));
					4: val = {32'($urandom), 1'b1, 31'($urandom)};
					default: val = 64'($urandom_range(1000)) - 64'd500;
				endcase
				flags = 5'($urandom);
				// mostly short fields, now and then past the clamp
				fw = ($urandom_range(9) == 0) ? 7'($urandom_range(127, 25))
					: 7'($urandom_range(24));
				md = ($urandom_range(7) == 0) ? 6'($urandom_range(63))
					: 6'($urandom_range(12));
				offer_request(val, 1'($urandom_range(1)), 1'($urandom_range(1)),
					2'($urandom_range(3)), flags[0], flags[1], flags[2], flags[3],
					flags[4], fw, md);
			end
		end

		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS integer_field_formatter");
		else
			$display("FAIL integer_field_formatter");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/iff_pkg.sv
hw/rtl/integer_field_formatter.sv
tb/iff_field_checker.sv
tb/tb_top.sv
